[src/rbs_pkg.sv]
// ----------------------------------------------------------------------------
// rbs_pkg
// shared types, constants and helper functions for the ray/box slab test
// ----------------------------------------------------------------------------
package rbs_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FIELD_W         = 32;
	localparam int DIST_W          = 31;
	localparam int ROOT_W          = 32;
	localparam int PROD_W          = 64;
	localparam int DIV_BITS        = 2;
	localparam int DIV_STAGES      = PROD_W / DIV_BITS;

	localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

	localparam logic signed [63:0] T_SAT     = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] T_SAT_NEG = 64'sh8000_0000_0000_0001;
	localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

	// per axis data ahead of the divide
	typedef struct packed {
		logic [31:0] dm;
		logic [31:0] em;
		logic [31:0] xm;
		logic        eneg;
		logic        xneg;
		logic        zero;
		logic        in_slab;
	} axis_t;

	// long division state: partial remainder and dividend/quotient shift word
	typedef struct packed {
		logic [31:0]       rem;
		logic [PROD_W-1:0] dv;
	} div_t;

	function automatic div_t div_step(input div_t s, input logic [31:0] dm);
		logic [32:0]       r;
		logic [PROD_W-1:0] dv;
		div_t              o;
		r  = {1'b0, s.rem};
		dv = s.dv;
		for (int i = 0; i < DIV_BITS; i++) begin
			r  = {r[31:0], dv[PROD_W-1]};
			dv = {dv[PROD_W-2:0], 1'b0};
			if (r >= {1'b0, dm}) begin
				r     = r - {1'b0, dm};
				dv[0] = 1'b1;
			end
		end
		o.rem = r[31:0];
		o.dv  = dv;
		return o;
	endfunction

	// quotient to signed slab parameter, saturated at +/-(2^63 - 1)
	function automatic logic signed [63:0] to_t(input logic [PROD_W-1:0] q, input logic neg);
		logic [63:0] m;
		m = q[PROD_W-1] ? 64'(T_SAT) : {1'b0, q[PROD_W-2:0]};
		return neg ? -$signed(m) : $signed(m);
	endfunction

endpackage

[src/ray_box_slab_intersect.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// ray against axis-aligned box, slab method, signed Q16.16 fixed point
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the result side stalls; 32-stage square root and
//   32-stage radix-4 dividers, one per slab bound, set the depth
// reset: valid bits and box registers clear; the pipeline drains empty
// a stall on the result side holds every stage while a result is valid
module ray_box_slab_intersect #(
	parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [rbs_pkg::FIELD_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rbs_pkg::FIELD_W-1:0]  origin_x,
	input  logic [rbs_pkg::FIELD_W-1:0]  origin_y,
	input  logic [rbs_pkg::FIELD_W-1:0]  origin_z,
	input  logic [rbs_pkg::FIELD_W-1:0]  heading_x,
	input  logic [rbs_pkg::FIELD_W-1:0]  heading_y,
	input  logic [rbs_pkg::FIELD_W-1:0]  heading_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [rbs_pkg::DIST_W-1:0]   distance
);
	import rbs_pkg::*;

	localparam int EW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;

	logic [FIELD_W-1:0] box_lo_q [3];
	logic [FIELD_W-1:0] box_hi_q [3];
	logic               en;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_lo_q[a] <= '0;
				box_hi_q[a] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BOX_MIN_X: box_lo_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_lo_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_lo_q[2] <= cfg_data;
				REG_BOX_MAX_X: box_hi_q[0] <= cfg_data;
				REG_BOX_MAX_Y: box_hi_q[1] <= cfg_data;
				REG_BOX_MAX_Z: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: slab differences, magnitudes, squares
	logic [FIELD_W-1:0] in_o [3];
	logic [FIELD_W-1:0] in_d [3];
	axis_t              ax_c [3];
	logic [63:0]        sq_c [3];

	assign in_o[0] = origin_x;
	assign in_o[1] = origin_y;
	assign in_o[2] = origin_z;
	assign in_d[0] = heading_x;
	assign in_d[1] = heading_y;
	assign in_d[2] = heading_z;

	always_comb begin
		logic signed [32:0] o, d, lo, hi, dl, dh, ed, xd;
		for (int a = 0; a < 3; a++) begin
			o  = 33'($signed(in_o[a][EW-1:0]));
			d  = 33'($signed(in_d[a][EW-1:0]));
			lo = 33'($signed(box_lo_q[a][EW-1:0]));
			hi = 33'($signed(box_hi_q[a][EW-1:0]));
			dl = lo - o;
			dh = hi - o;
			ed = (d > 0) ? dl : dh;
			xd = (d > 0) ? dh : dl;
			ax_c[a].dm      = d[32] ? 32'(-d) : 32'(d);
			ax_c[a].em      = ed[32] ? 32'(-ed) : 32'(ed);
			ax_c[a].xm      = xd[32] ? 32'(-xd) : 32'(xd);
			ax_c[a].eneg    = ed[32] != d[32];
			ax_c[a].xneg    = xd[32] != d[32];
			ax_c[a].zero    = (d == 0);
			ax_c[a].in_slab = !((o < lo) || (o > hi));
			sq_c[a]         = 64'(ax_c[a].dm) * 64'(ax_c[a].dm);
		end
	end

	logic        vld_s1;
	axis_t [2:0] ax_s1;
	logic [63:0] sq_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				ax_s1[a] <= ax_c[a];
				sq_s1[a] <= sq_c[a];
			end
		end
	end

	// stage 2: squared length
	logic              sqv_s [ROOT_W+1];
	logic [63:0]       sqx_s [ROOT_W+1];
	logic [ROOT_W-1:0] sqr_s [ROOT_W+1];
	axis_t [2:0]       sqa_s [ROOT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sqv_s[0] <= 1'b0;
		else if (en) sqv_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s[0] <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			sqr_s[0] <= '0;
			sqa_s[0] <= ax_s1;
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - k;
		logic [65:0] test;
		logic        ge;
		assign test = (66'(sqr_s[k]) << (B + 1)) + (66'd1 << (2 * B));
		assign ge   = 66'(sqx_s[k]) >= test;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqv_s[k+1] <= 1'b0;
			else if (en) sqv_s[k+1] <= sqv_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqx_s[k+1] <= ge ? 64'(66'(sqx_s[k]) - test) : sqx_s[k];
				sqr_s[k+1] <= ge ? (sqr_s[k] | (ROOT_W'(1) << B)) : sqr_s[k];
				sqa_s[k+1] <= sqa_s[k];
			end
		end
	end

	// scale by length
	logic        vld_sm;
	axis_t [2:0] ax_sm;
	div_t        dvi_sm [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sm <= 1'b0;
		else if (en) vld_sm <= sqv_s[ROOT_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_sm <= sqa_s[ROOT_W];
			for (int a = 0; a < 3; a++) begin
				dvi_sm[2*a].rem   <= '0;
				dvi_sm[2*a].dv    <= 64'(sqa_s[ROOT_W][a].em) * 64'(sqr_s[ROOT_W]);
				dvi_sm[2*a+1].rem <= '0;
				dvi_sm[2*a+1].dv  <= 64'(sqa_s[ROOT_W][a].xm) * 64'(sqr_s[ROOT_W]);
			end
		end
	end

	// dividers, entry and exit bound per axis
	logic        dvv_s [DIV_STAGES+1];
	axis_t [2:0] dva_s [DIV_STAGES+1];
	div_t        dvd_s [DIV_STAGES+1][6];

	assign dvv_s[0] = vld_sm;
	assign dva_s[0] = ax_sm;
	for (genvar l = 0; l < 6; l++) begin : g_dv0
		assign dvd_s[0][l] = dvi_sm[l];
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvv_s[k+1] <= 1'b0;
			else if (en) dvv_s[k+1] <= dvv_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dva_s[k+1] <= dva_s[k];
				for (int l = 0; l < 6; l++) begin
					dvd_s[k+1][l] <= div_step(dvd_s[k][l], dva_s[k][l/2].dm);
				end
			end
		end
	end

	// signed, saturated slab parameters
	logic               vld_st;
	logic signed [63:0] t0_st [3];
	logic signed [63:0] t1_st [3];
	logic [2:0]         zero_st;
	logic               ok_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_st <= 1'b0;
		else if (en) vld_st <= dvv_s[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				t0_st[a]   <= to_t(dvd_s[DIV_STAGES][2*a].dv, dva_s[DIV_STAGES][a].eneg);
				t1_st[a]   <= to_t(dvd_s[DIV_STAGES][2*a+1].dv, dva_s[DIV_STAGES][a].xneg);
				zero_st[a] <= dva_s[DIV_STAGES][a].zero;
			end
			ok_st <= !((dva_s[DIV_STAGES][0].zero && !dva_s[DIV_STAGES][0].in_slab) ||
			           (dva_s[DIV_STAGES][1].zero && !dva_s[DIV_STAGES][1].in_slab) ||
			           (dva_s[DIV_STAGES][2].zero && !dva_s[DIV_STAGES][2].in_slab));
		end
	end

	// interval intersection
	logic               vld_se;
	logic signed [63:0] entry_se, exit_se;
	logic               ok_se;
	logic signed [63:0] entry_c, exit_c;

	always_comb begin
		entry_c = T_SAT_NEG;
		exit_c  = T_SAT;
		for (int a = 0; a < 3; a++) begin
			if (!zero_st[a]) begin
				if (t0_st[a] > entry_c) entry_c = t0_st[a];
				if (t1_st[a] < exit_c) exit_c = t1_st[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_se <= 1'b0;
		else if (en) vld_se <= vld_st;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entry_se <= entry_c;
			exit_se  <= exit_c;
			ok_se    <= ok_st;
		end
	end

	// result
	logic signed [63:0] res_c;
	logic               hit_c;

	assign res_c = (entry_se >= 0) ? entry_se : exit_se;
	assign hit_c = ok_se && !(entry_se > exit_se) && (res_c >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_se;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= hit_c;
			if (!hit_c) distance <= '0;
			else if (res_c > 64'(DIST_MAX)) distance <= DIST_MAX;
			else distance <= res_c[DIST_W-1:0];
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect testbench
// drives rays against a programmed box with random idling on both sides,
// predicts hit and distance for every ray and checks results in order
// ----------------------------------------------------------------------------
module tb;
	import rbs_pkg::*;

	localparam int LATENCY   = 70;
	localparam int MAX_CYCLES = 400000;
	localparam logic signed [63:0] T_BIG = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [31:0] o[3];
		logic [31:0] d[3];
	} ray_t;

	typedef struct {
		logic        hit;
		logic [30:0] distance;
	} hit_t;

	typedef struct {
		logic [31:0] o[3];
		logic [31:0] d[3];
		logic        known;
		logic        hit;
		logic [30:0] distance;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = REG_BOX_MIN_X;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic [31:0] heading_x = '0, heading_y = '0, heading_z = '0;
	logic out_valid;
	logic out_stall = 1;
	logic hit;
	logic [30:0] distance;

	logic [31:0] box_lo[3];
	logic [31:0] box_hi[3];
	hit_t expected_hits[$];
	int errors = 0;
	int cycles = 0;
	bit hold_off = 0;
	int hold_cycles = 0;

	always #1 clk = ~clk;

	ray_box_slab_intersect DUT (.*);

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] slab_param(input logic signed [63:0] diff,
			input logic signed [63:0] d, input logic [63:0] len);
		logic [63:0] m, q;
		logic [127:0] p;
		m = mag(diff);
		if (m == 0)
			return 0;
		p = m * len;
		if (p[127:64] != 0)
			q = T_BIG;
		else
			q = p[63:0] / mag(d);
		if (q > T_BIG)
			q = T_BIG;
		return ((diff < 0) != (d < 0)) ? -$signed(q) : $signed(q);
	endfunction

	function automatic hit_t trace_ray(input ray_t r);
		logic signed [63:0] o, d, lo, hi, t0, t1, near_t, far_t, res;
		logic [63:0] sum, len;
		bit ok;
		hit_t h;
		near_t = -T_BIG;
		far_t = T_BIG;
		ok = 1;
		sum = 0;
		for (int a = 0; a < 3; a++)
			sum += mag($signed(r.d[a])) * mag($signed(r.d[a]));
		len = root64(sum);
		for (int a = 0; a < 3; a++) begin
			o = $signed(r.o[a]);
			d = $signed(r.d[a]);
			lo = $signed(box_lo[a]);
			hi = $signed(box_hi[a]);
			if (d == 0) begin
				if (o < lo || o > hi)
					ok = 0;
				continue;
			end
			if (d > 0) begin
				t0 = slab_param(lo - o, d, len);
				t1 = slab_param(hi - o, d, len);
			end else begin
				t0 = slab_param(hi - o, d, len);
				t1 = slab_param(lo - o, d, len);
			end
			if (t0 > near_t)
				near_t = t0;
			if (t1 < far_t)
				far_t = t1;
		end
		res = near_t >= 0 ? near_t : far_t;
		if (!ok || near_t > far_t || res < 0) begin
			h.hit = 0;
			h.distance = 0;
		end else begin
			h.hit = 1;
			h.distance = res > 64'sh7FFF_FFFF ? DIST_MAX : res[30:0];
		end
		return h;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_BOX_MIN_X: box_lo[0] = val;
			REG_BOX_MIN_Y: box_lo[1] = val;
			REG_BOX_MIN_Z: box_lo[2] = val;
			REG_BOX_MAX_X: box_hi[0] = val;
			REG_BOX_MAX_Y: box_hi[1] = val;
			default: box_hi[2] = val;
		endcase
	endtask

	task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
		write_reg(REG_BOX_MIN_X, lx);
		write_reg(REG_BOX_MIN_Y, ly);
		write_reg(REG_BOX_MIN_Z, lz);
		write_reg(REG_BOX_MAX_X, hx);
		write_reg(REG_BOX_MAX_Y, hy);
		write_reg(REG_BOX_MAX_Z, hz);
		cfg_valid <= 0;
	endtask

	task automatic drain;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic int gap_len;
		int g;
		g = $urandom_range(0, 99);
		if (g < 50)
			return 0;
		return g < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	task automatic send_ray(input ray_t r, input bit known, input hit_t want);
		hit_t h;
		int g;
		h = trace_ray(r);
		if (known && (h.hit !== want.hit || h.distance !== want.distance)) begin
			$error("table row: hit exp %0d got %0d, distance exp %0h got %0h",
				want.hit, h.hit, want.distance, h.distance);
			errors++;
		end
		in_valid <= 1;
		origin_x <= r.o[0];
		origin_y <= r.o[1];
		origin_z <= r.o[2];
		heading_x <= r.d[0];
		heading_y <= r.d[1];
		heading_z <= r.d[2];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_hits.push_back(h);
		g = $urandom_range(0, 1) ? gap_len() : 0;
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 0;
			default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
		endcase
	endfunction

	function automatic ray_t rand_ray;
		ray_t r;
		for (int a = 0; a < 3; a++) begin
			r.o[a] = rand_coord($urandom_range(0, 9) < 2 ? $urandom_range(0, 2) : 3);
			r.d[a] = rand_coord($urandom_range(0, 9) < 3 ? $urandom_range(0, 2) : 3);
		end
		return r;
	endfunction

	task automatic random_rays(input int n);
		ray_t r;
		hit_t none;
		none = '{0, 0};
		for (int i = 0; i < n; i++) begin
			r = rand_ray();
			send_ray(r, 0, none);
		end
		in_valid <= 0;
	endtask

	// result side: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (hold_off) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles + 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 25) ||
				($urandom_range(0, 99) < 3 && out_stall);
		end
	end

	always @(posedge clk) begin
		hit_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_hits.size() == 0) begin
				$error("unexpected item: hit %0d distance %0h", hit, distance);
				errors++;
			end else begin
				e = expected_hits.pop_front();
				if (hit !== e.hit) begin
					$error("hit: expected %0d actual %0d", e.hit, hit);
					errors++;
				end
				if (distance !== e.distance) begin
					$error("distance: expected %0h actual %0h", e.distance, distance);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] M1  = 32'hFFFF_0000;
	localparam logic [31:0] TWO = 32'h0002_0000;
	localparam logic [31:0] M5  = 32'hFFFB_0000;
	localparam logic [31:0] PMX = 32'h7FFF_FFFF;
	localparam logic [31:0] NMX = 32'h8000_0000;

	row_t rows[] = '{
		// reset box at origin, ray through it
		'{'{M5, 0, 0}, '{ONE, 0, 0}, 1, 1, 31'h0005_0000},
		'{'{0, 0, 0}, '{0, 0, 0}, 1, 1, DIST_MAX},
		'{'{ONE, 0, 0}, '{0, 0, 0}, 1, 0, 0},
		'{'{ONE, 0, 0}, '{ONE, 0, 0}, 1, 0, 0},
		'{'{0, M5, 0}, '{0, TWO, 0}, 1, 1, 31'h0005_0000},
		'{'{0, 0, M5}, '{0, 0, M1}, 1, 0, 0},
		'{'{NMX, 0, 0}, '{PMX, 0, 0}, 1, 1, 31'h7FFF_FFFF},
		'{'{PMX, PMX, PMX}, '{NMX, NMX, NMX}, 0, 0, 0},
		'{'{NMX, NMX, NMX}, '{PMX, PMX, PMX}, 0, 0, 0},
		'{'{M5, M5, M5}, '{ONE, ONE, ONE}, 0, 0, 0},
		'{'{M5, ONE, 0}, '{ONE, 0, 0}, 1, 0, 0},
		'{'{M5, M5, 0}, '{ONE, M1, 0}, 0, 0, 0}
	};

	initial begin
		ray_t r;
		hit_t w;
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = 0;
			box_hi[a] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) begin
			r.o = rows[i].o;
			r.d = rows[i].d;
			w.hit = rows[i].hit;
			w.distance = rows[i].distance;
			send_ray(r, rows[i].known, w);
		end
		in_valid <= 0;
		drain();
		// unit-ish box, then touching and inverted boxes
		set_box(M1, M1, M1, ONE, ONE, ONE);
		r.o = '{M5, 0, 0}; r.d = '{ONE, 0, 0}; w = '{1, 31'h0004_0000};
		send_ray(r, 1, w);
		r.o = '{0, 0, 0}; r.d = '{0, TWO, 0}; w = '{1, 31'h0001_0000};
		send_ray(r, 1, w);
		r.o = '{M5, ONE, 0}; r.d = '{ONE, 0, 0}; w = '{1, 31'h0004_0000};
		send_ray(r, 1, w);
		r.o = '{M5, M5, 0}; r.d = '{ONE, ONE, 0};
		send_ray(r, 0, w);
		random_rays(120);
		drain();
		set_box(ONE, ONE, ONE, M1, M1, M1);
		r.o = '{0, 0, 0}; r.d = '{ONE, ONE, ONE}; w = '{0, 0};
		send_ray(r, 1, w);
		random_rays(40);
		drain();
		set_box(NMX, NMX, NMX, PMX, PMX, PMX);
		random_rays(90);
		drain();
		// long hold-off while rays keep coming
		set_box(32'hFFF6_0000, 32'hFFF6_0000, 32'hFFF6_0000,
			32'h000A_0000, 32'h000A_0000, 32'h000A_0000);
		hold_off = 1;
		fork
			random_rays(100);
			begin
				while (hold_cycles < 300)
					@(posedge clk);
				hold_off = 0;
			end
		join
		drain();
		set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		random_rays(40);
		drain();
		set_box(32'hFFFD_8000, M5, 0, 32'h0003_0000, TWO, 32'h0000_8000);
		random_rays(60);
		drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

[sim.f]
src/rbs_pkg.sv
src/ray_box_slab_intersect.sv
test/tb.sv
